>>> design/ifrag_pkg.sv
// Package for the IPv4 fragmenter: transfer payload types, result kind codes,
// microcode control word format and the microprogram itself.
// Depends on nothing; used by ifrag_useq and ipv4_fragmenter.
`timescale 1ns / 1ps
`default_nettype none

package ifrag_pkg;

  localparam int MaxFragmentsDefault = 64;
  localparam int MtuWidth            = 16;
  localparam int NumPorts            = 4;
  localparam logic [MtuWidth-1:0] MtuReset = 16'd1500;

  localparam logic [1:0] KIND_FORWARD       = 2'd0;
  localparam logic [1:0] KIND_FRAGMENT      = 2'd1;
  localparam logic [1:0] KIND_ICMP_DROP     = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW_DROP = 2'd3;

  typedef struct packed {
    logic [15:0] dgram_length;
    logic [5:0]  header_length;
    logic        dont_fragment;
    logic        more_frags_in;
    logic [1:0]  output_port;
    logic [31:0] next_hop_addr;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] frag_length;
    logic [15:0] frag_offset;
    logic        more_frags_out;
    logic [1:0]  port_out;
    logic [31:0] hop_out;
    logic        last_of_run;
  } out_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_WAIT  = 4'd0;
  localparam step_t STEP_FIT   = 4'd1;
  localparam step_t STEP_DF    = 4'd2;
  localparam step_t STEP_HDR   = 4'd3;
  localparam step_t STEP_COUNT = 4'd4;
  localparam step_t STEP_FWD   = 4'd5;
  localparam step_t STEP_ICMP  = 4'd6;
  localparam step_t STEP_OVF   = 4'd7;
  localparam step_t STEP_FRAG  = 4'd8;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SUB,
    ACT_MUL,
    ACT_INIT,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_ACC,
    COND_FITS,
    COND_DF,
    COND_HDR_GE,
    COND_TOO_MANY,
    COND_LAST
  } cond_t;

  typedef struct packed {
    act_t       act;
    logic [1:0] kind;
    cond_t      cond;
    step_t      t_true;
    step_t      t_false;
  } ucode_t;

  typedef struct packed {
    logic in_acc;
    logic fits;
    logic df;
    logic hdr_ge;
    logic too_many;
    logic last;
    logic out_busy;
  } flags_t;

  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    unique case (step)
      STEP_WAIT:  w = '{ACT_LOAD, KIND_FORWARD, COND_IN_ACC, STEP_FIT, STEP_WAIT};
      STEP_FIT:   w = '{ACT_SUB, KIND_FORWARD, COND_FITS, STEP_FWD, STEP_DF};
      STEP_DF:    w = '{ACT_MUL, KIND_FORWARD, COND_DF, STEP_ICMP, STEP_HDR};
      STEP_HDR:   w = '{ACT_NONE, KIND_FORWARD, COND_HDR_GE, STEP_OVF, STEP_COUNT};
      STEP_COUNT: w = '{ACT_INIT, KIND_FORWARD, COND_TOO_MANY, STEP_OVF, STEP_FRAG};
      STEP_FWD:   w = '{ACT_EMIT, KIND_FORWARD, COND_ALWAYS, STEP_WAIT, STEP_WAIT};
      STEP_ICMP:  w = '{ACT_EMIT, KIND_ICMP_DROP, COND_ALWAYS, STEP_WAIT, STEP_WAIT};
      STEP_OVF:   w = '{ACT_EMIT, KIND_OVERFLOW_DROP, COND_ALWAYS, STEP_WAIT, STEP_WAIT};
      STEP_FRAG:  w = '{ACT_EMIT, KIND_FRAGMENT, COND_LAST, STEP_WAIT, STEP_FRAG};
      default:    w = '{ACT_NONE, KIND_FORWARD, COND_ALWAYS, STEP_WAIT, STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/ifrag_useq.sv
// Microcode sequencer of the IPv4 fragmenter: step counter, control store
// and conditional jump logic. Depends on ifrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifrag_useq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ifrag_pkg::flags_t flags,
  output ifrag_pkg::ucode_t      word
);

  ifrag_pkg::step_t step_r;
  ifrag_pkg::step_t step_nxt;
  logic             taken;

  assign word = ifrag_pkg::ucode_rom(step_r);

  always_comb begin
    unique case (word.cond)
      ifrag_pkg::COND_ALWAYS:   taken = 1'b1;
      ifrag_pkg::COND_IN_ACC:   taken = flags.in_acc;
      ifrag_pkg::COND_FITS:     taken = flags.fits;
      ifrag_pkg::COND_DF:       taken = flags.df;
      ifrag_pkg::COND_HDR_GE:   taken = flags.hdr_ge;
      ifrag_pkg::COND_TOO_MANY: taken = flags.too_many;
      ifrag_pkg::COND_LAST:     taken = flags.last;
      default:                  taken = 1'b1;
    endcase
  end

  always_comb begin
    priority if (word.act == ifrag_pkg::ACT_EMIT && flags.out_busy) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = word.t_true;
    end else begin
      step_nxt = word.t_false;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ifrag_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ipv4_fragmenter.sv
// IPv4 datagram fragmenter, usage:
// A datagram descriptor arrives on in_valid/in_ready/in_data. The MTU of the
// chosen port (cfg_we/cfg_index/cfg_wdata, four 16-bit registers, 1500 after
// reset) decides whether it is forwarded, dropped for ICMP, dropped as an
// overflow (header not below the MTU, or too many fragments), or cut into
// fragments. Results leave on out_valid/out_ready/out_data, one per transfer,
// last_of_run marking the final one of a datagram.
// One descriptor is processed at a time. The microprogram loads it, checks
// whether it fits the MTU, then the DF bit, then whether the header fits,
// then the fragment count, stopping at the first check that settles the
// result; it then emits one result, or one result per fragment. The fragment
// count check uses one 16 by 7 bit multiply registered during the DF check step.
// A result waits in the output register while out_ready is low; the sequencer
// holds on its emit step and no new descriptor is taken until the run ends.
// Synchronous reset returns the sequencer to waiting and clears out_valid;
// in_ready stays low while rst_n is low.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_fragmenter #(
  parameter int MAX_FRAGMENTS = ifrag_pkg::MaxFragmentsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ifrag_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ifrag_pkg::out_t      out_data,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_wdata
);

  localparam int MW = $clog2(MAX_FRAGMENTS + 1);
  localparam int LW = ifrag_pkg::MtuWidth + MW;

  logic [15:0] mtu_regs_r [ifrag_pkg::NumPorts];

  ifrag_pkg::ucode_t word;
  ifrag_pkg::flags_t flags;

  logic [15:0] total_r;
  logic [5:0]  hdr_r;
  logic        df_r;
  logic        mfin_r;
  logic [1:0]  port_r;
  logic [31:0] hop_r;
  logic [15:0] mtu_r;
  logic [15:0] chunk_r;
  logic [15:0] payload_r;
  logic [LW-1:0] limit_r;
  logic [15:0] off_r;
  logic [15:0] rem_r;

  logic            out_valid_r;
  ifrag_pkg::out_t out_data_r;
  logic            push;
  logic            is_last;
  ifrag_pkg::out_t result;

  ifrag_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .word  (word)
  );

  assign in_ready  = (word.act == ifrag_pkg::ACT_LOAD) && rst_n;
  assign is_last   = (rem_r <= chunk_r);
  assign push      = (word.act == ifrag_pkg::ACT_EMIT) && !flags.out_busy;

  always_comb begin
    flags.in_acc   = in_valid && in_ready;
    flags.fits     = (total_r <= mtu_r);
    flags.df       = df_r;
    flags.hdr_ge   = ({10'd0, hdr_r} >= mtu_r);
    flags.too_many = ({{MW{1'b0}}, payload_r} > limit_r);
    flags.last     = is_last;
    flags.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    result.result_kind = word.kind;
    result.port_out    = port_r;
    result.hop_out     = hop_r;
    if (word.kind == ifrag_pkg::KIND_FRAGMENT) begin
      result.frag_length    = is_last ? (total_r - off_r) : mtu_r;
      result.frag_offset    = off_r;
      result.more_frags_out = is_last ? mfin_r : 1'b1;
      result.last_of_run    = is_last;
    end else begin
      result.frag_length    = total_r;
      result.frag_offset    = 16'd0;
      result.more_frags_out = mfin_r;
      result.last_of_run    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ifrag_pkg::NumPorts; i++) begin
        mtu_regs_r[i] <= ifrag_pkg::MtuReset;
      end
    end else if (cfg_we) begin
      mtu_regs_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (flags.in_acc) begin
      total_r <= in_data.dgram_length;
      hdr_r   <= in_data.header_length;
      df_r    <= in_data.dont_fragment;
      mfin_r  <= in_data.more_frags_in;
      port_r  <= in_data.output_port;
      hop_r   <= in_data.next_hop_addr;
      mtu_r   <= mtu_regs_r[in_data.output_port];
    end
    if (word.act == ifrag_pkg::ACT_SUB) begin
      chunk_r   <= mtu_r - {10'd0, hdr_r};
      payload_r <= total_r - {10'd0, hdr_r};
    end
    if (word.act == ifrag_pkg::ACT_MUL) begin
      limit_r <= LW'(chunk_r) * LW'(MAX_FRAGMENTS);
    end
    if (word.act == ifrag_pkg::ACT_INIT) begin
      off_r <= 16'd0;
      rem_r <= payload_r;
    end else if (push && word.kind == ifrag_pkg::KIND_FRAGMENT) begin
      off_r <= off_r + chunk_r;
      rem_r <= rem_r - chunk_r;
    end
    if (push) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> tb/ipv4_fragmenter_tb.sv
// Self-checking testbench for ipv4_fragmenter: directed table then randomised datagrams,
// with each result checked against a given kind or a behavioural fragmentation predictor.
// Depends on ifrag_pkg and ipv4_fragmenter.
`timescale 1ns / 1ps

module ipv4_fragmenter_tb;

  localparam int FragLimit     = ifrag_pkg::MaxFragmentsDefault;
  localparam int HoldCycles    = 300;
  localparam int IdleLimit     = 4000;
  localparam int RandPhases    = 8;
  localparam int ItemsPerPhase = 13;

  typedef struct {
    bit             is_cfg;
    logic [1:0]     reg_idx;
    logic [15:0]    reg_val;
    ifrag_pkg::in_t dgram;
    bit             typed;
    logic [1:0]     kind;
  } dir_row_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  ifrag_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ifrag_pkg::out_t out_data;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [15:0]     cfg_wdata = '0;

  logic [15:0]     port_mtu [ifrag_pkg::NumPorts];
  ifrag_pkg::out_t frag_queue [$];
  dir_row_t        dir_rows [$];
  int              errors      = 0;
  int              idle_cycles = 0;
  int              burst_left  = 0;
  bit              hold_req    = 1'b0;

  ipv4_fragmenter #(.MAX_FRAGMENTS(FragLimit)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic ifrag_pkg::out_t whole_result(ifrag_pkg::in_t d, logic [1:0] kind);
    ifrag_pkg::out_t r;
    r.result_kind    = kind;
    r.frag_length    = d.dgram_length;
    r.frag_offset    = '0;
    r.more_frags_out = d.more_frags_in;
    r.port_out       = d.output_port;
    r.hop_out        = d.next_hop_addr;
    r.last_of_run    = 1'b1;
    return r;
  endfunction

  function automatic void predict_fragments(ifrag_pkg::in_t d);
    int unsigned mtu, hdr, tot, chunk, n;
    ifrag_pkg::out_t r;
    mtu = 32'(port_mtu[d.output_port]);
    hdr = 32'(d.header_length);
    tot = 32'(d.dgram_length);
    if (tot <= mtu) begin
      frag_queue.push_back(whole_result(d, ifrag_pkg::KIND_FORWARD));
      return;
    end
    if (d.dont_fragment) begin
      frag_queue.push_back(whole_result(d, ifrag_pkg::KIND_ICMP_DROP));
      return;
    end
    if (hdr >= mtu) begin
      frag_queue.push_back(whole_result(d, ifrag_pkg::KIND_OVERFLOW_DROP));
      return;
    end
    chunk = mtu - hdr;
    n = (tot - hdr + chunk - 1) / chunk;
    if (n > int'(FragLimit)) begin
      frag_queue.push_back(whole_result(d, ifrag_pkg::KIND_OVERFLOW_DROP));
      return;
    end
    r = whole_result(d, ifrag_pkg::KIND_FRAGMENT);
    for (int unsigned i = 0; i < n; i++) begin
      r.frag_offset = 16'(i * chunk);
      if (i + 1 < n) begin
        r.frag_length    = 16'(mtu);
        r.more_frags_out = 1'b1;
        r.last_of_run    = 1'b0;
      end else begin
        r.frag_length    = 16'(tot - i * chunk);
        r.more_frags_out = d.more_frags_in;
        r.last_of_run    = 1'b1;
      end
      frag_queue.push_back(r);
    end
  endfunction

  function automatic void add_item(int tot, int hdr, int df, int mf, int port,
                                   logic [31:0] hop, int typed, logic [1:0] kind);
    dir_row_t row;
    row.is_cfg              = 1'b0;
    row.reg_idx             = '0;
    row.reg_val             = '0;
    row.dgram.dgram_length  = 16'(tot);
    row.dgram.header_length = 6'(hdr);
    row.dgram.dont_fragment = 1'(df);
    row.dgram.more_frags_in = 1'(mf);
    row.dgram.output_port   = 2'(port);
    row.dgram.next_hop_addr = hop;
    row.typed               = 1'(typed);
    row.kind                = kind;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int idx, int val);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = 2'(idx);
    row.reg_val = 16'(val);
    row.dgram   = '0;
    row.typed   = 1'b0;
    row.kind    = ifrag_pkg::KIND_FORWARD;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [15:0] pick_mtu();
    case ($urandom_range(0, 7))
      0:       return 16'd68;
      1:       return 16'hFFFF;
      2:       return 16'd1500;
      3:       return 16'd576;
      4:       return 16'($urandom_range(68, 9000));
      5:       return 16'($urandom_range(0, 67));
      6:       return 16'($urandom_range(20000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ifrag_pkg::in_t random_datagram();
    ifrag_pkg::in_t d;
    int unsigned mtu, hdr, chunk, k, tot, sel;
    d.next_hop_addr = $urandom;
    d.output_port   = 2'($urandom_range(0, 3));
    d.more_frags_in = 1'($urandom_range(0, 1));
    d.dont_fragment = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0) begin
      d.header_length = 6'($urandom);
      d.dgram_length  = 16'($urandom);
      return d;
    end
    hdr = $urandom_range(5, 15) * 4;
    mtu = 32'(port_mtu[d.output_port]);
    d.header_length = 6'(hdr);
    sel = $urandom_range(0, 9);
    if (mtu <= hdr) begin
      tot = $urandom_range(0, 65535);
    end else if (sel < 3) begin
      tot = $urandom_range(hdr, mtu);
    end else begin
      chunk = mtu - hdr;
      k = (sel == 9) ? $urandom_range(9, 70) : $urandom_range(2, 8);
      tot = hdr + chunk * k - $urandom_range(0, chunk - 1);
      if (tot > 65535) begin
        tot = (mtu < 65535) ? $urandom_range(mtu + 1, 65535) : 65535;
      end
    end
    d.dgram_length = 16'(tot);
    return d;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic send_datagram(ifrag_pkg::in_t d, bit typed, logic [1:0] kind);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      frag_queue.push_back(whole_result(d, kind));
    end else begin
      predict_fragments(d);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (frag_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_mtu(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    port_mtu[idx] = val;
  endtask

  always @(posedge clk) begin
    ifrag_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frag_queue.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, got %p", $time, out_data);
      end else begin
        want = frag_queue.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
        check_field("frag_length", 32'(want.frag_length), 32'(out_data.frag_length));
        check_field("frag_offset", 32'(want.frag_offset), 32'(out_data.frag_offset));
        check_field("more_frags_out", 32'(want.more_frags_out),
                    32'(out_data.more_frags_out));
        check_field("port_out", 32'(want.port_out), 32'(out_data.port_out));
        check_field("hop_out", want.hop_out, out_data.hop_out);
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("ipv4_fragmenter_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver alternates between always ready, random stalls and a fixed
  // pattern, and holds off completely for a long stretch when asked.
  initial begin : rx_stall
    int len, mode, tick;
    tick = 0;
    forever begin
      if (hold_req) begin
        repeat (HoldCycles) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 2) != 0);
          default: out_ready <= (tick % 3 != 0);
        endcase
        tick++;
      end
    end
  end

  initial begin : stimulus
    for (int p = 0; p < ifrag_pkg::NumPorts; p++) port_mtu[p] = ifrag_pkg::MtuReset;

    add_item(20, 20, 0, 0, 0, 32'h0000_0000, 1, ifrag_pkg::KIND_FORWARD);
    add_item(1500, 20, 0, 1, 1, 32'hFFFF_FFFF, 1, ifrag_pkg::KIND_FORWARD);
    add_item(1501, 20, 1, 0, 2, 32'h0A00_0001, 1, ifrag_pkg::KIND_ICMP_DROP);
    add_item(65535, 60, 1, 1, 3, 32'hC0A8_0101, 1, ifrag_pkg::KIND_ICMP_DROP);
    add_item(1501, 20, 0, 1, 0, 32'h5555_AAAA, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(4460, 20, 0, 0, 1, 32'hAAAA_5555, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(3000, 0, 0, 1, 2, 32'h1234_5678, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(5000, 63, 0, 1, 3, 32'h8765_4321, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(65535, 20, 0, 0, 0, 32'hDEAD_BEEF, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(0, 0, 0, 1, 1, 32'h0000_0001, 1, ifrag_pkg::KIND_FORWARD);
    add_cfg(0, 68);
    add_cfg(1, 0);
    add_cfg(2, 40);
    add_cfg(3, 65535);
    add_item(65535, 63, 0, 1, 3, 32'h8000_0000, 1, ifrag_pkg::KIND_FORWARD);
    add_item(100, 60, 0, 0, 2, 32'h0102_0304, 1, ifrag_pkg::KIND_OVERFLOW_DROP);
    add_item(100, 40, 1, 1, 2, 32'h0506_0708, 1, ifrag_pkg::KIND_ICMP_DROP);
    add_item(41, 40, 0, 0, 2, 32'h090A_0B0C, 1, ifrag_pkg::KIND_OVERFLOW_DROP);
    add_item(0, 20, 1, 1, 1, 32'h0D0E_0F10, 1, ifrag_pkg::KIND_FORWARD);
    add_item(1, 0, 0, 0, 1, 32'h1112_1314, 1, ifrag_pkg::KIND_OVERFLOW_DROP);
    add_item(3092, 20, 0, 1, 0, 32'hCAFE_F00D, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(3093, 20, 0, 0, 0, 32'hFEED_FACE, 1, ifrag_pkg::KIND_OVERFLOW_DROP);
    add_item(69, 20, 0, 1, 0, 32'h7F00_0001, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(68, 20, 1, 0, 0, 32'h7F00_0002, 1, ifrag_pkg::KIND_FORWARD);
    add_cfg(0, 65535);
    add_cfg(1, 1500);
    add_cfg(2, 21);
    add_cfg(3, 20);
    add_item(1300, 20, 0, 0, 2, 32'hA5A5_A5A5, 1, ifrag_pkg::KIND_OVERFLOW_DROP);
    add_item(84, 20, 0, 1, 2, 32'h5A5A_5A5A, 0, ifrag_pkg::KIND_FRAGMENT);
    add_item(21, 20, 0, 0, 3, 32'h0F0F_0F0F, 1, ifrag_pkg::KIND_OVERFLOW_DROP);
    add_item(65535, 63, 1, 0, 0, 32'hF0F0_F0F0, 1, ifrag_pkg::KIND_FORWARD);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_mtu(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_datagram(dir_rows[i].dgram, dir_rows[i].typed, dir_rows[i].kind);
      end
    end

    // In the third phase the receiver stops for a long time while datagrams
    // keep arriving, so the block has to push back on its input.
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_drained();
      for (int p = 0; p < ifrag_pkg::NumPorts; p++) write_mtu(2'(p), pick_mtu());
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        send_datagram(random_datagram(), 1'b0, ifrag_pkg::KIND_FORWARD);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0 && frag_queue.size() == 0) begin
      $display("ipv4_fragmenter_tb: PASS");
    end else begin
      $display("ipv4_fragmenter_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/ifrag_pkg.sv
design/ifrag_useq.sv
design/ipv4_fragmenter.sv
tb/ipv4_fragmenter_tb.sv
